>>> rtl/pulse_distance_frame_decoder_assert.svh
// Assertion macros used by the pulse distance frame decoder back end.
`ifndef PULSE_DISTANCE_FRAME_DECODER_ASSERT_SVH
`define PULSE_DISTANCE_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PDFD_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pdfd assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PDFD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pdfd assertion failed");

`endif

>>> rtl/pdfd_pkg.sv
// Shared types and constants of the pulse distance frame decoder.
`default_nettype none
package pdfd_pkg;

   // Default width of the pulse duration field.
   localparam int DURATION_WIDTH_DEF = 24;

   // Register widths and reset values.
   localparam int UNIT_WIDTH = 16;
   localparam int TOL_WIDTH  = 12;
   localparam logic [UNIT_WIDTH-1:0] UNIT_SHORT_RESET = 16'd600;
   localparam logic [UNIT_WIDTH-1:0] UNIT_LONG_RESET  = 16'd1800;
   localparam logic [TOL_WIDTH-1:0]  TOLERANCE_RESET  = 12'd100;

   // Preamble and bit timing multipliers.
   localparam int PRE_HIGH_UNITS = 16;
   localparam int PRE_LOW_UNITS  = 8;
   localparam int PRE_HIGH_TOL   = 7;
   localparam int PRE_LOW_TOL    = 5;
   localparam int ONE_TOL        = 2;

   // Widest scaled target (16 * unit_short) and widest scaled tolerance (7 * tolerance).
   localparam int TARGET_WIDTH     = 20;
   localparam int TOL_SCALED_WIDTH = 15;

   // Frame layout.
   localparam int COUNT_WIDTH = 6;
   localparam logic [COUNT_WIDTH-1:0] FRAME_BITS = 6'd32;
   localparam int CODE_WIDTH = 32;
   localparam logic [7:0] BYTE_MASK = 8'hFF;

   // Configuration port.
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic [1:0] REG_UNIT_SHORT = 2'd0;
   localparam logic [1:0] REG_UNIT_LONG  = 2'd1;
   localparam logic [1:0] REG_TOLERANCE  = 2'd2;

   // Queue between the classifier and the frame machine.
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_WIDTH = 1;

   // Current register contents.
   typedef struct packed {
      logic [UNIT_WIDTH-1:0] unit_short;
      logic [UNIT_WIDTH-1:0] unit_long;
      logic [TOL_WIDTH-1:0]  tolerance;
   } cfg_type;

   // Classification of one pulse against every window the machine can ask for.
   typedef struct packed {
      logic level;
      logic pre_high;
      logic pre_low;
      logic short_pulse;
      logic long_pulse;
   } class_type;

   localparam int CLASS_WIDTH = $bits(class_type);

endpackage
`default_nettype wire

>>> rtl/pulse_distance_frame_decoder.sv
// Top level of the pulse distance frame decoder: registers, classifier, queue, frame machine.
//
//   Channel | Direction | tdata                     | tuser
//   req_    | in        | [DW-1:0] duration         | [0] level
//   rsp_    | out       | [31:0] frame_code         | [0] frame_valid, [1] check_failed
//   csr_    | in/out    | APB registers unit_short @0, unit_long @4, tolerance @8
//
// One pulse per cycle is accepted while the result side keeps up, and one result per pulse is returned.
// Each pulse is held in the classifier queue and then in the result register.
// The frame machine's state update sets the rate.
// Reset is synchronous; there is no clearing pass.
// A stalled result side fills the two-word queue, after which req_tready drops.
`default_nettype none
module pulse_distance_frame_decoder
   import pdfd_pkg::*;
#(
   parameter int DURATION_WIDTH = DURATION_WIDTH_DEF,
   localparam int REQ_TDATA_WIDTH = ((DURATION_WIDTH + 7) / 8) * 8
)(
   input  wire logic                       clock,
   input  wire logic                       reset,
   // Pulse words.
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [REQ_TDATA_WIDTH-1:0] req_tdata,  // duration, zero padded
   input  wire logic                       req_tuser,  // level
   // Result words.
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic      [CODE_WIDTH-1:0]      rsp_tdata,  // frame_code
   output logic      [1:0]                 rsp_tuser,  // frame_valid, check_failed
   // Register port.
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int QW = DURATION_WIDTH + CLASS_WIDTH;

   cfg_type                   cfg;
   class_type                 in_class, q_class;
   logic                      q_push, q_not_full, q_pop, q_not_empty;
   logic [QW-1:0]             q_push_data, q_pop_data;
   logic                      frame_valid, check_failed;

   pdfd_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .cfg        (cfg)
   );

   pdfd_front #(.DURATION_WIDTH(DURATION_WIDTH)) u_front (
      .cfg        (cfg),
      .level      (req_tuser),
      .duration   (req_tdata[DURATION_WIDTH-1:0]),
      .pulse_class(in_class)
   );

   // Accept a pulse whenever the queue has room.
   assign req_tready  = q_not_full;
   assign q_push      = req_tvalid & q_not_full;
   assign q_push_data = {req_tdata[DURATION_WIDTH-1:0], in_class};

   pdfd_queue #(.DATA_WIDTH(QW)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_push_data),
      .not_full (q_not_full),
      .pop      (q_pop),
      .not_empty(q_not_empty),
      .pop_data (q_pop_data)
   );

   assign q_class = q_pop_data[CLASS_WIDTH-1:0];

   pdfd_back #(.DURATION_WIDTH(DURATION_WIDTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .q_not_empty (q_not_empty),
      .q_class     (q_class),
      .q_duration  (q_pop_data[QW-1:CLASS_WIDTH]),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .frame_valid (frame_valid),
      .frame_code  (rsp_tdata),
      .check_failed(check_failed)
   );

   assign rsp_tuser = {check_failed, frame_valid};

endmodule
`default_nettype wire

>>> rtl/pdfd_csr.sv
// Configuration registers behind the APB-style port.
`default_nettype none
module pdfd_csr
   import pdfd_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready,
   output cfg_type                        cfg
);

   logic [UNIT_WIDTH-1:0] unit_short_ff, unit_short_in;
   logic [UNIT_WIDTH-1:0] unit_long_ff, unit_long_in;
   logic [TOL_WIDTH-1:0]  tolerance_ff, tolerance_in;
   logic                  wr_en;
   logic [1:0]            reg_index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_index  = csr_paddr[3:2];

   // Register write decode; writes beyond the list are dropped.
   always_comb begin
      unit_short_in = unit_short_ff;
      unit_long_in  = unit_long_ff;
      tolerance_in  = tolerance_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_UNIT_SHORT: unit_short_in = csr_pwdata[UNIT_WIDTH-1:0];
            REG_UNIT_LONG:  unit_long_in  = csr_pwdata[UNIT_WIDTH-1:0];
            REG_TOLERANCE:  tolerance_in  = csr_pwdata[TOL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_short_ff <= UNIT_SHORT_RESET;
         unit_long_ff  <= UNIT_LONG_RESET;
         tolerance_ff  <= TOLERANCE_RESET;
      end else begin
         unit_short_ff <= unit_short_in;
         unit_long_ff  <= unit_long_in;
         tolerance_ff  <= tolerance_in;
      end
   end

   // Read-back mux.
   always_comb begin
      unique case (reg_index)
         REG_UNIT_SHORT: csr_prdata = CSR_DATA_WIDTH'(unit_short_ff);
         REG_UNIT_LONG:  csr_prdata = CSR_DATA_WIDTH'(unit_long_ff);
         REG_TOLERANCE:  csr_prdata = CSR_DATA_WIDTH'(tolerance_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg.unit_short = unit_short_ff;
   assign cfg.unit_long  = unit_long_ff;
   assign cfg.tolerance  = tolerance_ff;

endmodule
`default_nettype wire

>>> rtl/pdfd_front.sv
// Front end: classifies each pulse against the preamble and bit windows.
`default_nettype none
module pdfd_front
   import pdfd_pkg::*;
#(
   parameter int DURATION_WIDTH = DURATION_WIDTH_DEF
)(
   input  wire cfg_type              cfg,
   input  wire logic                 level,
   input  wire logic [DURATION_WIDTH-1:0] duration,
   output class_type                 pulse_class
);

   // Compare width covers both the duration and the widest target.
   localparam int CW = (DURATION_WIDTH > TARGET_WIDTH) ? DURATION_WIDTH : TARGET_WIDTH;

   logic [CW-1:0]               dur_ext;
   logic [CW-1:0]               tgt_pre_high, tgt_pre_low, tgt_short, tgt_long;
   logic [TOL_SCALED_WIDTH-1:0] tol_pre_high, tol_pre_low, tol_short, tol_long;

   // Strict window test on the absolute difference.
   function automatic logic near_fn(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                    input logic [TOL_SCALED_WIDTH-1:0] t);
      logic [CW-1:0] diff;
      diff = (a > b) ? (a - b) : (b - a);
      return diff < CW'(t);
   endfunction

   assign dur_ext = CW'(duration);

   // Scaled targets and tolerances; all multipliers are small constants.
   assign tgt_pre_high = CW'(cfg.unit_short) * CW'(PRE_HIGH_UNITS);
   assign tgt_pre_low  = CW'(cfg.unit_short) * CW'(PRE_LOW_UNITS);
   assign tgt_short    = CW'(cfg.unit_short);
   assign tgt_long     = CW'(cfg.unit_long);
   assign tol_pre_high = TOL_SCALED_WIDTH'(cfg.tolerance) * TOL_SCALED_WIDTH'(PRE_HIGH_TOL);
   assign tol_pre_low  = TOL_SCALED_WIDTH'(cfg.tolerance) * TOL_SCALED_WIDTH'(PRE_LOW_TOL);
   assign tol_short    = TOL_SCALED_WIDTH'(cfg.tolerance);
   assign tol_long     = TOL_SCALED_WIDTH'(cfg.tolerance) * TOL_SCALED_WIDTH'(ONE_TOL);

   assign pulse_class.level       = level;
   assign pulse_class.pre_high    = near_fn(dur_ext, tgt_pre_high, tol_pre_high);
   assign pulse_class.pre_low     = near_fn(dur_ext, tgt_pre_low, tol_pre_low);
   assign pulse_class.short_pulse = near_fn(dur_ext, tgt_short, tol_short);
   assign pulse_class.long_pulse  = near_fn(dur_ext, tgt_long, tol_long);

endmodule
`default_nettype wire

>>> rtl/pdfd_queue.sv
// Short queue between the classifier and the frame machine.
`default_nettype none
module pdfd_queue
   import pdfd_pkg::*;
#(
   parameter int DATA_WIDTH = DURATION_WIDTH_DEF + CLASS_WIDTH
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic [DATA_WIDTH-1:0] push_data,
   output logic                       not_full,
   input  wire logic                  pop,
   output logic                       not_empty,
   output logic      [DATA_WIDTH-1:0] pop_data
);

   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_WIDTH-1:0]      slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]       count_ff, count_in;

   assign not_full  = (count_ff != CNT_WIDTH'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   // Pointer and fill-count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage slots carry no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

>>> rtl/pdfd_back.sv
// Back end: frame state machine, bit shifter, complement check and output register.
`default_nettype none
`include "pulse_distance_frame_decoder_assert.svh"
module pdfd_back
   import pdfd_pkg::*;
#(
   parameter int DURATION_WIDTH = DURATION_WIDTH_DEF
)(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cfg_type                   cfg,
   input  wire logic                      q_not_empty,
   input  wire class_type                 q_class,
   input  wire logic [DURATION_WIDTH-1:0] q_duration,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           frame_valid,
   output logic      [CODE_WIDTH-1:0]     frame_code,
   output logic                           check_failed
);

   // Phase codes.
   localparam logic [1:0] PH_HUNT_HIGH = 2'd0;
   localparam logic [1:0] PH_HUNT_LOW  = 2'd1;
   localparam logic [1:0] PH_BIT_HIGH  = 2'd2;
   localparam logic [1:0] PH_BIT_LOW   = 2'd3;

   logic [1:0]                phase_ff, phase_in;
   logic [CODE_WIDTH-1:0]     shift_ff, shift_in;
   logic [COUNT_WIDTH-1:0]    bit_count_ff, bit_count_in;
   logic [DURATION_WIDTH-1:0] last_high_ff, last_high_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      frame_valid_ff, frame_valid_in;
   logic                      check_failed_ff, check_failed_in;
   logic [CODE_WIDTH-1:0]     frame_code_ff, frame_code_in;
   logic [DURATION_WIDTH-1:0] us_ext, lh_diff;
   logic                      last_near, code_ok;

   // Take a word whenever the output register is free or being emptied.
   assign q_pop = q_not_empty & (~rsp_valid_ff | rsp_ready);

   // The stored high pulse is checked against the current short window.
   assign us_ext    = DURATION_WIDTH'(cfg.unit_short);
   assign lh_diff   = (last_high_ff > us_ext) ? (last_high_ff - us_ext) : (us_ext - last_high_ff);
   assign last_near = lh_diff < DURATION_WIDTH'(cfg.tolerance);

   // Complement check over the two byte pairs.
   assign code_ok = ((shift_ff[31:24] ^ shift_ff[23:16]) == BYTE_MASK) &&
                    ((shift_ff[15:8] ^ shift_ff[7:0]) == BYTE_MASK);

   // Next state and result for the word at the head of the queue.
   always_comb begin
      phase_in        = phase_ff;
      shift_in        = shift_ff;
      bit_count_in    = bit_count_ff;
      last_high_in    = last_high_ff;
      frame_valid_in  = 1'b0;
      check_failed_in = 1'b0;
      frame_code_in   = '0;
      unique case (phase_ff)
         PH_HUNT_HIGH: begin
            if (q_class.level && q_class.pre_high) begin
               phase_in = PH_HUNT_LOW;
            end
         end
         PH_HUNT_LOW: begin
            phase_in     = (!q_class.level && q_class.pre_low) ? PH_BIT_HIGH : PH_HUNT_HIGH;
            shift_in     = '0;
            bit_count_in = '0;
         end
         PH_BIT_HIGH: begin
            if (q_class.level && q_class.short_pulse) begin
               if (bit_count_ff == FRAME_BITS) begin
                  frame_code_in   = shift_ff;
                  frame_valid_in  = code_ok;
                  check_failed_in = ~code_ok;
                  phase_in        = PH_HUNT_HIGH;
                  shift_in        = '0;
                  bit_count_in    = '0;
               end else begin
                  last_high_in = q_duration;
                  phase_in     = PH_BIT_LOW;
               end
            end else begin
               phase_in     = PH_HUNT_HIGH;
               shift_in     = '0;
               bit_count_in = '0;
            end
         end
         PH_BIT_LOW: begin
            if (!q_class.level && last_near && q_class.short_pulse) begin
               shift_in     = {shift_ff[CODE_WIDTH-2:0], 1'b0};
               bit_count_in = bit_count_ff + COUNT_WIDTH'(1);
               phase_in     = PH_BIT_HIGH;
            end else if (!q_class.level && last_near && q_class.long_pulse) begin
               shift_in     = {shift_ff[CODE_WIDTH-2:0], 1'b1};
               bit_count_in = bit_count_ff + COUNT_WIDTH'(1);
               phase_in     = PH_BIT_HIGH;
            end else begin
               phase_in     = PH_HUNT_HIGH;
               shift_in     = '0;
               bit_count_in = '0;
            end
         end
         default: begin
            phase_in     = PH_HUNT_HIGH;
            shift_in     = '0;
            bit_count_in = '0;
         end
      endcase
   end

   assign rsp_valid_in = q_pop | (rsp_valid_ff & ~rsp_ready);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT_HIGH;
         shift_ff     <= '0;
         bit_count_ff <= '0;
         last_high_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            phase_ff     <= phase_in;
            shift_ff     <= shift_in;
            bit_count_ff <= bit_count_in;
            last_high_ff <= last_high_in;
         end
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         frame_valid_ff  <= frame_valid_in;
         check_failed_ff <= check_failed_in;
         frame_code_ff   <= frame_code_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign frame_valid  = frame_valid_ff;
   assign check_failed = check_failed_ff;
   assign frame_code   = frame_code_ff;

   // A result is either accepted or rejected, never both.
   `PDFD_ASSERT_IMPL(a_flags_exclusive, clock, reset, rsp_valid_ff, !(frame_valid_ff && check_failed_ff))
   // Only a frame end carries a code.
   `PDFD_ASSERT_IMPL(a_code_only_at_end, clock, reset, rsp_valid_ff && !frame_valid_ff && !check_failed_ff, frame_code_ff == '0)
   // The bit counter never runs past a full frame.
   `PDFD_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, bit_count_ff <= FRAME_BITS)
   // While hunting for the preamble no bits are held.
   `PDFD_ASSERT_IMPL(a_hunt_clear, clock, reset, phase_ff == PH_HUNT_HIGH || phase_ff == PH_HUNT_LOW, bit_count_ff == '0 && shift_ff == '0)
   // A low bit pulse always leads back to a bit high phase or to the hunt.
   `PDFD_ASSERT_NEXT(a_low_exit, clock, reset, q_pop && phase_ff == PH_BIT_LOW, phase_ff == PH_BIT_HIGH || phase_ff == PH_HUNT_HIGH)

endmodule
`default_nettype wire

>>> tb/sv/pulse_distance_frame_decoder_tb.sv
// Self-checking testbench for the pulse distance frame decoder with a built-in frame predictor.
`timescale 1ns / 100ps

module pulse_distance_frame_decoder_tb;
   import pdfd_pkg::*;

   localparam int DUR_W = DURATION_WIDTH_DEF;
   localparam logic [1:0] REG_SPARE = 2'd3;

   typedef logic [DUR_W-1:0] dur_type;

   // Receiver phases: preamble high, preamble low, bit high, bit low.
   localparam logic [1:0] HUNT_HIGH = 2'd0;
   localparam logic [1:0] HUNT_LOW  = 2'd1;
   localparam logic [1:0] BIT_HIGH  = 2'd2;
   localparam logic [1:0] BIT_LOW   = 2'd3;

   typedef struct packed {
      logic                  valid;
      logic [CODE_WIDTH-1:0] code;
      logic                  failed;
   } frame_result_type;

   localparam frame_result_type NO_FRAME = '0;

   typedef struct packed {
      logic             lvl;
      dur_type          dur;
      logic             typed;
      frame_result_type want;
   } opening_pulse_type;

   typedef struct packed {
      logic [UNIT_WIDTH-1:0] short_us;
      logic [UNIT_WIDTH-1:0] long_us;
      logic [TOL_WIDTH-1:0]  tol_us;
      logic                  steady;
      logic                  pick_random;
      logic [11:0]           budget;
   } timing_setting_type;

   // Opening pulses under the reset timing (short 600, long 1800, tolerance 100).
   localparam opening_pulse_type OPENING_PULSES [26] = '{
      '{1'b0, 24'd0,        1'b1, NO_FRAME},   // shortest low pulse while hunting
      '{1'b1, 24'hFFFFFF,   1'b1, NO_FRAME},   // saturated high pulse while hunting
      '{1'b1, 24'd9600,     1'b0, NO_FRAME},   // exact preamble high
      '{1'b0, 24'd4800,     1'b0, NO_FRAME},   // exact preamble low
      '{1'b1, 24'd600,      1'b0, NO_FRAME},   // bit high
      '{1'b0, 24'd600,      1'b0, NO_FRAME},   // zero bit
      '{1'b1, 24'd699,      1'b0, NO_FRAME},   // bit high at the inner tolerance edge
      '{1'b0, 24'd1999,     1'b0, NO_FRAME},   // one bit at the inner tolerance edge
      '{1'b1, 24'd500,      1'b0, NO_FRAME},   // bit high just outside: misfit
      '{1'b1, 24'd10299,    1'b0, NO_FRAME},   // preamble high at the inner edge
      '{1'b0, 24'd4301,     1'b0, NO_FRAME},   // preamble low at the inner edge
      '{1'b1, 24'd600,      1'b0, NO_FRAME},
      '{1'b0, 24'd2000,     1'b0, NO_FRAME},   // long low just outside: misfit
      '{1'b1, 24'd8900,     1'b0, NO_FRAME},   // preamble high just outside: ignored
      '{1'b1, 24'd8901,     1'b0, NO_FRAME},
      '{1'b1, 24'd4800,     1'b0, NO_FRAME},   // preamble low with the wrong level
      '{1'b1, 24'd9600,     1'b0, NO_FRAME},
      '{1'b0, 24'd5300,     1'b0, NO_FRAME},   // preamble low just outside
      '{1'b1, 24'd9600,     1'b0, NO_FRAME},
      '{1'b0, 24'd4800,     1'b0, NO_FRAME},
      '{1'b0, 24'd600,      1'b0, NO_FRAME},   // bit high with the wrong level
      '{1'b1, 24'd9600,     1'b0, NO_FRAME},
      '{1'b0, 24'd4800,     1'b0, NO_FRAME},
      '{1'b1, 24'd600,      1'b0, NO_FRAME},
      '{1'b1, 24'd600,      1'b0, NO_FRAME},   // bit low with the wrong level
      '{1'b0, 24'hFFFFFF,   1'b1, NO_FRAME}    // saturated low pulse while hunting
   };

   // Timing settings applied in turn after the opening phase.
   localparam timing_setting_type TIMING_SETTINGS [6] = '{
      '{16'd1,     16'd3,     12'd1,     1'b0, 1'b0, 12'd240},
      '{16'hFFFF,  16'hFFFF,  12'hFFF,   1'b1, 1'b0, 12'd240},
      '{16'd250,   16'd900,   12'd60,    1'b0, 1'b0, 12'd240},
      '{16'd0,     16'd0,     12'd0,     1'b0, 1'b0, 12'd60},
      '{16'd0,     16'd0,     12'd0,     1'b0, 1'b1, 12'd240},
      '{16'd600,   16'd1800,  12'd100,   1'b0, 1'b0, 12'd240}
   };

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   dur_type                   req_tdata;   // duration
   logic                      req_tuser;   // level
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b1;
   logic [CODE_WIDTH-1:0]     rsp_tdata;   // frame_code
   logic [1:0]                rsp_tuser;   // frame_valid, check_failed
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   // Predictor copy of the registers and of the receiver.
   logic [UNIT_WIDTH-1:0]  cfg_short;
   logic [UNIT_WIDTH-1:0]  cfg_long;
   logic [TOL_WIDTH-1:0]   cfg_tol;
   logic [1:0]             rx_phase;
   logic [CODE_WIDTH-1:0]  rx_bits;
   logic [COUNT_WIDTH-1:0] rx_count;
   dur_type                rx_last_high;

   frame_result_type pending_results[$];
   int               error_count = 0;
   int               pulses_sent = 0;
   int               good_frames = 0;
   int               bad_frames = 0;
   int               settings_used = 1;
   bit               steady = 1'b0;
   int               ready_hold = 0;

   pulse_distance_frame_decoder #(.DURATION_WIDTH(DUR_W)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Clock with a 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard limit on the run time.
   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   // Gap length: mostly none, sometimes short, rarely long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Strict-less-than window test on the absolute difference.
   function automatic bit near_to(longint unsigned d, longint unsigned target,
                                  longint unsigned tol);
      return ((d > target) ? d - target : target - d) < tol;
   endfunction

   function automatic void drop_frame();
      rx_phase = HUNT_HIGH;
      rx_bits  = '0;
      rx_count = '0;
   endfunction

   // Advance the receiver by one pulse and return the result word it produces.
   function automatic frame_result_type decode_pulse(logic lvl, dur_type dur);
      frame_result_type res;
      longint unsigned  d;
      longint unsigned  us;
      longint unsigned  tol;
      logic             ok;
      res = NO_FRAME;
      d   = dur;
      us  = cfg_short;
      tol = cfg_tol;
      case (rx_phase)
         HUNT_HIGH: begin
            if (lvl && near_to(d, us * PRE_HIGH_UNITS, tol * PRE_HIGH_TOL))
               rx_phase = HUNT_LOW;
         end
         HUNT_LOW: begin
            if (!lvl && near_to(d, us * PRE_LOW_UNITS, tol * PRE_LOW_TOL)) begin
               rx_phase = BIT_HIGH;
               rx_bits  = '0;
               rx_count = '0;
            end else begin
               drop_frame();
            end
         end
         BIT_HIGH: begin
            if (lvl && near_to(d, us, tol)) begin
               if (rx_count == FRAME_BITS) begin
                  // The frame ends here; both byte pairs must be complements.
                  ok = ((rx_bits[31:24] ^ rx_bits[23:16]) == BYTE_MASK) &&
                       ((rx_bits[15:8] ^ rx_bits[7:0]) == BYTE_MASK);
                  res.code   = rx_bits;
                  res.valid  = ok;
                  res.failed = !ok;
                  drop_frame();
               end else begin
                  rx_last_high = dur;
                  rx_phase     = BIT_LOW;
               end
            end else begin
               drop_frame();
            end
         end
         default: begin
            // A short low is a zero bit and wins over the long window.
            if (!lvl && near_to(rx_last_high, us, tol) && near_to(d, us, tol)) begin
               rx_bits  = rx_bits << 1;
               rx_count = rx_count + 1'b1;
               rx_phase = BIT_HIGH;
            end else if (!lvl && near_to(rx_last_high, us, tol) &&
                         near_to(d, cfg_long, tol * ONE_TOL)) begin
               rx_bits  = (rx_bits << 1) | 1'b1;
               rx_count = rx_count + 1'b1;
               rx_phase = BIT_HIGH;
            end else begin
               drop_frame();
            end
         end
      endcase
      return res;
   endfunction

   function automatic dur_type clamp_duration(longint v);
      if (v < 0) return '0;
      if (v > longint'({DUR_W{1'b1}})) return '1;
      return dur_type'(v);
   endfunction

   // Duration inside the window, often right at its inner edge.
   function automatic dur_type jitter(longint target, longint tol);
      longint offset;
      if (tol <= 0) return clamp_duration(target);
      case ($urandom_range(0, 7))
         0: offset = tol - 1;
         1: offset = 1 - tol;
         default: offset = longint'($urandom_range(0, 2 * tol - 2)) - (tol - 1);
      endcase
      return clamp_duration(target + offset);
   endfunction

   function automatic dur_type noise_duration();
      if ($urandom_range(0, 1) != 0) return dur_type'($urandom);
      return dur_type'($urandom_range(0, 20000));
   endfunction

   // Present one pulse word and record its expected result once accepted.
   task automatic send_pulse(logic lvl, dur_type dur, logic typed, frame_result_type want);
      frame_result_type res;
      int               gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= dur;
      req_tuser  <= lvl;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      res = decode_pulse(lvl, dur);
      pending_results.push_back(typed ? want : res);
      pulses_sent++;
   endtask

   // Drop the request and wait until every result word has come back.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One register access: setup cycle, then access cycle, then an idle cycle.
   task automatic csr_access(bit wr, logic [1:0] idx, logic [CSR_DATA_WIDTH-1:0] wdata,
                             output logic [CSR_DATA_WIDTH-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CSR_ADDR_WIDTH'({idx, 2'b00});
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write all timing registers plus the unused slot, then read the timing registers back.
   task automatic load_timing(logic [UNIT_WIDTH-1:0] short_us, logic [UNIT_WIDTH-1:0] long_us,
                              logic [TOL_WIDTH-1:0] tol_us);
      logic [CSR_DATA_WIDTH-1:0] rd;
      csr_access(1'b1, REG_UNIT_SHORT, {$urandom_range(0, 65535), short_us}, rd);
      cfg_short = short_us;
      csr_access(1'b1, REG_UNIT_LONG, {$urandom_range(0, 65535), long_us}, rd);
      cfg_long = long_us;
      csr_access(1'b1, REG_TOLERANCE, {$urandom_range(0, 1048575), tol_us}, rd);
      cfg_tol = tol_us;
      csr_access(1'b1, REG_SPARE, $urandom, rd);
      csr_access(1'b0, REG_UNIT_SHORT, '0, rd);
      if (rd !== CSR_DATA_WIDTH'(cfg_short)) begin
         $error("unit_short readback: expected %0d, got %0d", cfg_short, rd);
         error_count++;
      end
      csr_access(1'b0, REG_UNIT_LONG, '0, rd);
      if (rd !== CSR_DATA_WIDTH'(cfg_long)) begin
         $error("unit_long readback: expected %0d, got %0d", cfg_long, rd);
         error_count++;
      end
      csr_access(1'b0, REG_TOLERANCE, '0, rd);
      if (rd !== CSR_DATA_WIDTH'(cfg_tol)) begin
         $error("tolerance readback: expected %0d, got %0d", cfg_tol, rd);
         error_count++;
      end
   endtask

   task automatic send_noise();
      send_pulse($urandom_range(0, 1), noise_duration(), 1'b0, NO_FRAME);
   endtask

   // One frame with random content; some are damaged at one pulse or cut short.
   task automatic send_frame();
      logic            lv[$];
      longint          tgt[$];
      longint          win[$];
      logic [31:0]     code;
      longint          us;
      longint          tol;
      int              damage;
      int              k;
      logic            lvl;
      dur_type         dur;
      us  = cfg_short;
      tol = cfg_tol;
      if ($urandom_range(0, 9) < 6) begin
         code[31:24] = $urandom;
         code[23:16] = ~code[31:24];
         code[15:8]  = $urandom;
         code[7:0]   = ~code[15:8];
      end else begin
         code = $urandom;
      end
      lv.push_back(1'b1); tgt.push_back(us * PRE_HIGH_UNITS); win.push_back(tol * PRE_HIGH_TOL);
      lv.push_back(1'b0); tgt.push_back(us * PRE_LOW_UNITS);  win.push_back(tol * PRE_LOW_TOL);
      for (int i = 31; i >= 0; i--) begin
         lv.push_back(1'b1); tgt.push_back(us); win.push_back(tol);
         lv.push_back(1'b0);
         if (code[i]) begin
            tgt.push_back(cfg_long);
            win.push_back(tol * ONE_TOL);
         end else begin
            tgt.push_back(us);
            win.push_back(tol);
         end
      end
      lv.push_back(1'b1); tgt.push_back(us); win.push_back(tol);
      damage = $urandom_range(0, 99);
      k = $urandom_range(0, lv.size() - 1);
      foreach (lv[i]) begin
         lvl = lv[i];
         dur = jitter(tgt[i], win[i]);
         if (i == k) begin
            if (damage >= 94) break;
            if (damage >= 88) lvl = ~lvl;
            else if (damage >= 80) dur = noise_duration();
            else if (damage >= 70)
               dur = clamp_duration($urandom_range(0, 1) ? tgt[i] + win[i] : tgt[i] - win[i]);
         end
         send_pulse(lvl, dur, 1'b0, NO_FRAME);
      end
   endtask

   task automatic run_random(int budget);
      int start;
      start = pulses_sent;
      while (pulses_sent - start < budget) begin
         repeat ($urandom_range(0, 2)) send_noise();
         send_frame();
      end
   endtask

   // Result side: random stalls, with steady stretches.
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (steady || $urandom_range(0, 2) != 0) begin
         rsp_tready <= 1'b1;
         ready_hold <= $urandom_range(0, 7);
      end else begin
         rsp_tready <= 1'b0;
         ready_hold <= pick_gap();
      end
   end

   // Compare each result word with the oldest expected one.
   always @(posedge clock) begin : check_results
      frame_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result word with no pulse outstanding");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser[0] !== want.valid) begin
               $error("frame_valid: expected %0b, got %0b", want.valid, rsp_tuser[0]);
               error_count++;
            end
            if (rsp_tdata !== want.code) begin
               $error("frame_code: expected %08h, got %08h", want.code, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser[1] !== want.failed) begin
               $error("check_failed: expected %0b, got %0b", want.failed, rsp_tuser[1]);
               error_count++;
            end
            if (want.valid) good_frames++;
            if (want.failed) bad_frames++;
         end
      end
   end

   // Main sequence.
   initial begin
      timing_setting_type s;
      logic [UNIT_WIDTH-1:0] rand_short;
      logic [UNIT_WIDTH-1:0] rand_long;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      cfg_short    = UNIT_SHORT_RESET;
      cfg_long     = UNIT_LONG_RESET;
      cfg_tol      = TOLERANCE_RESET;
      rx_last_high = '0;
      drop_frame();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (OPENING_PULSES[i])
         send_pulse(OPENING_PULSES[i].lvl, OPENING_PULSES[i].dur,
                    OPENING_PULSES[i].typed, OPENING_PULSES[i].want);
      run_random(220);

      foreach (TIMING_SETTINGS[i]) begin
         s = TIMING_SETTINGS[i];
         settle();
         if (s.pick_random) begin
            rand_short = $urandom_range(50, 3000);
            rand_long  = (rand_short * $urandom_range(2, 4) > 65535) ?
                         16'hFFFF : rand_short * $urandom_range(2, 4);
            load_timing(rand_short, rand_long, $urandom_range(1, rand_short / 3));
         end else begin
            load_timing(s.short_us, s.long_us, s.tol_us);
         end
         steady = s.steady;
         settings_used++;
         run_random(s.budget);
      end

      steady = 1'b0;
      settle();
      repeat (8) @(posedge clock);
      $display("Sent %0d pulse words under %0d timing settings.", pulses_sent, settings_used);
      $display("Frames seen: %0d passed the byte check, %0d failed it.",
               good_frames, bad_frames);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
